// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and the arctangent table for the Euler-to-quaternion
// block.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_STEPS_CFG = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CORDIC_STEPS     = (CORDIC_STEPS_CFG > TABLE_LEN) ? TABLE_LEN
                                                                   : CORDIC_STEPS_CFG;
  localparam int AW = 16;   // angle and component width
  localparam int CW = 34;   // CORDIC datapath width, Q30 plus guard bits
  localparam int SW = 26;   // sine/cosine width, Q24 plus sign

  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] OUT_MAX     = 16'sd16384;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [CW-1:0] z_roll;
    logic signed [CW-1:0] z_pitch;
    logic signed [CW-1:0] z_yaw;
    logic [2:0]           flip;
  } folded_t;

  typedef struct packed {
    logic signed [AW-1:0] w;
    logic signed [AW-1:0] i;
    logic signed [AW-1:0] j;
    logic signed [AW-1:0] k;
  } quat_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    case (idx)
      0: atan_q30 = 34'sd843314856;   1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043836;   3: atan_q30 = 34'sd133525158;
      4: atan_q30 = 34'sd67021686;    5: atan_q30 = 34'sd33543515;
      6: atan_q30 = 34'sd16775850;    7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194282;     9: atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048575;    11: atan_q30 = 34'sd524287;
      12: atan_q30 = 34'sd262143;     13: atan_q30 = 34'sd131071;
      14: atan_q30 = 34'sd65535;      15: atan_q30 = 34'sd32767;
      16: atan_q30 = 34'sd16383;      17: atan_q30 = 34'sd8191;
      18: atan_q30 = 34'sd4095;       19: atan_q30 = 34'sd2047;
      20: atan_q30 = 34'sd1023;       21: atan_q30 = 34'sd511;
      22: atan_q30 = 34'sd255;        23: atan_q30 = 34'sd127;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

// ===== rtl/e2q_front.sv =====
// ----------------------------------------------------------------------------
// e2q_front
// Halve the three angles, fold them into the CORDIC range and queue them.
// ----------------------------------------------------------------------------
module e2q_front import e2q_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  output logic    in_full,
  input  angles_t in_ang,
  output logic    q_valid,
  input  logic    q_take,
  output folded_t q_data
);

  folded_t              mem [QDEPTH];
  logic [QAW-1:0]       wp_r, rp_r;
  logic [QAW:0]         cnt_r, cnt_nxt;
  folded_t              fold;
  logic                 do_push, do_pop;

  function automatic void fold_one(input logic signed [AW-1:0] a,
                                   output logic signed [CW-1:0] z,
                                   output logic f);
    logic signed [CW-1:0] h;
    h = {{(CW-AW-16){a[AW-1]}}, a, 16'd0};
    if (h > HALF_PI_Q30) begin
      z = h - PI_Q30; f = 1'b1;
    end else if (h < -HALF_PI_Q30) begin
      z = h + PI_Q30; f = 1'b1;
    end else begin
      z = h; f = 1'b0;
    end
  endfunction

  always_comb begin
    fold = '0;
    fold_one(in_ang.roll,  fold.z_roll,  fold.flip[0]);
    fold_one(in_ang.pitch, fold.z_pitch, fold.flip[1]);
    fold_one(in_ang.yaw,   fold.z_yaw,   fold.flip[2]);
  end

  assign in_full = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign do_push = in_push && !in_full;
  assign do_pop  = q_take && q_valid;
  assign q_data  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= fold;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !q_take |=> cnt_r == (QAW+1)'(QDEPTH)) else $error("full queue lost entry");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[QAW-1:0]) else $error("queue pointers out of step");

endmodule

// ===== rtl/e2q_back.sv =====
// ----------------------------------------------------------------------------
// e2q_back
// Pipelined CORDIC for three angles, then products and saturation.
// Stalls as a whole when the output holds.
// ----------------------------------------------------------------------------
module e2q_back import e2q_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_take,
  input  folded_t q_data,
  output logic    out_empty,
  input  logic    out_pop,
  output quat_t   out_q
);

  localparam int NS = CORDIC_STEPS + 6;  // load + cordic + round + pair + triple + sum + out
  localparam int PW = 2*SW;

  logic                 vld_r [NS];
  logic                 adv;
  logic signed [CW-1:0] x_r [CORDIC_STEPS+1][3];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1][3];
  logic signed [CW-1:0] z_r [CORDIC_STEPS+1][3];
  logic [2:0]           fl_r [CORDIC_STEPS+1];
  logic signed [SW-1:0] s_r [3], c_r [3];
  logic signed [SW-1:0] p_r [8];          // pair products, Q24
  logic signed [SW-1:0] t3_r [8];         // third factor of each term
  logic signed [2*SW-1:0] t_r [8];        // triple products, Q48
  logic signed [2*SW+1:0] sum_r [4];
  quat_t                o_r;

  assign adv       = !vld_r[NS-1] || out_pop;
  assign q_take    = adv;
  assign out_empty = !vld_r[NS-1];
  assign out_q     = o_r;

  function automatic logic signed [SW-1:0] rnd6(input logic signed [CW-1:0] v, input logic f);
    logic signed [CW-1:0] r;
    r = (v + 34'sd32) >>> 6;
    rnd6 = f ? -r[SW-1:0] : r[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] pmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [PW-1:0] m;
    m = (a * b + (PW'(1) <<< 23)) >>> 24;
    pmul = m[SW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] fin(input logic signed [2*SW+1:0] v);
    logic signed [2*SW+1:0] r;
    r = (v + ((2*SW+2)'(1) <<< 33)) >>> 34;
    if (r > 16384) fin = OUT_MAX;
    else if (r < -16384) fin = -OUT_MAX;
    else fin = r[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NS; n++) vld_r[n] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
      for (int n = 1; n < NS; n++) vld_r[n] <= vld_r[n-1];
    end
  end

  // advance payload: stage 0 loads folded angles
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0][0] <= GAIN_Q30; x_r[0][1] <= GAIN_Q30; x_r[0][2] <= GAIN_Q30;
      y_r[0][0] <= '0; y_r[0][1] <= '0; y_r[0][2] <= '0;
      z_r[0][0] <= q_data.z_roll; z_r[0][1] <= q_data.z_pitch;
      z_r[0][2] <= q_data.z_yaw;
      fl_r[0] <= q_data.flip;
      for (int st = 0; st < CORDIC_STEPS; st++) begin
        fl_r[st+1] <= fl_r[st];
        for (int a = 0; a < 3; a++) begin
          if (!z_r[st][a][CW-1]) begin
            x_r[st+1][a] <= x_r[st][a] - (y_r[st][a] >>> st);
            y_r[st+1][a] <= y_r[st][a] + (x_r[st][a] >>> st);
            z_r[st+1][a] <= z_r[st][a] - atan_q30(st);
          end else begin
            x_r[st+1][a] <= x_r[st][a] + (y_r[st][a] >>> st);
            y_r[st+1][a] <= y_r[st][a] - (x_r[st][a] >>> st);
            z_r[st+1][a] <= z_r[st][a] + atan_q30(st);
          end
        end
      end
      for (int a = 0; a < 3; a++) begin
        s_r[a] <= rnd6(y_r[CORDIC_STEPS][a], fl_r[CORDIC_STEPS][a]);
        c_r[a] <= rnd6(x_r[CORDIC_STEPS][a], fl_r[CORDIC_STEPS][a]);
      end
      // 0 cr*cp*cy 1 sr*sp*sy 2 sr*cp*cy 3 cr*sp*sy
      // 4 cr*sp*cy 5 sr*cp*sy 6 cr*cp*sy 7 sr*sp*cy
      p_r[0] <= pmul(c_r[0], c_r[1]); t3_r[0] <= c_r[2];
      p_r[1] <= pmul(s_r[0], s_r[1]); t3_r[1] <= s_r[2];
      p_r[2] <= pmul(s_r[0], c_r[1]); t3_r[2] <= c_r[2];
      p_r[3] <= pmul(c_r[0], s_r[1]); t3_r[3] <= s_r[2];
      p_r[4] <= pmul(c_r[0], s_r[1]); t3_r[4] <= c_r[2];
      p_r[5] <= pmul(s_r[0], c_r[1]); t3_r[5] <= s_r[2];
      p_r[6] <= pmul(c_r[0], c_r[1]); t3_r[6] <= s_r[2];
      p_r[7] <= pmul(s_r[0], s_r[1]); t3_r[7] <= c_r[2];
      for (int m = 0; m < 8; m++) t_r[m] <= p_r[m] * t3_r[m];
      sum_r[0] <= (2*SW+2)'(t_r[0]) + (2*SW+2)'(t_r[1]);
      sum_r[1] <= (2*SW+2)'(t_r[2]) - (2*SW+2)'(t_r[3]);
      sum_r[2] <= (2*SW+2)'(t_r[4]) + (2*SW+2)'(t_r[5]);
      sum_r[3] <= (2*SW+2)'(t_r[6]) - (2*SW+2)'(t_r[7]);
      o_r.w <= fin(sum_r[0]); o_r.i <= fin(sum_r[1]);
      o_r.j <= fin(sum_r[2]); o_r.k <= fin(sum_r[3]);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(o_r)) else $error("result dropped");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> o_r.w <= OUT_MAX && o_r.w >= -OUT_MAX) else $error("w not saturated");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> q_take) else $error("pipeline stalled while output empty");

endmodule

// ===== rtl/euler_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Roll/pitch/yaw (Q13 radians) to ZYX unit quaternion (Q14, saturated).
// ----------------------------------------------------------------------------
// The block takes one angle triple per cycle while in_full is low and returns one
// quaternion per triple, in order. A triple passes the queue, a load stage, one
// CORDIC stage per step, then rounding, pair product, triple product, sum and
// saturation stages. The front folds the half angles and writes a four-entry
// queue; the back pipeline pulls from it and stalls as a unit only while a
// finished result waits on the output, so a held pop backs up into the queue
// and then full.
module euler_to_quaternion_top import e2q_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic signed [AW-1:0] in_roll_angle,
  input  logic signed [AW-1:0] in_pitch_angle,
  input  logic signed [AW-1:0] in_yaw_angle,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [AW-1:0] out_scalar_part,
  output logic signed [AW-1:0] out_i_part,
  output logic signed [AW-1:0] out_j_part,
  output logic signed [AW-1:0] out_k_part
);

  angles_t ang;
  folded_t qd;
  logic    qv, qt;
  quat_t   q;

  assign ang.roll  = in_roll_angle;
  assign ang.pitch = in_pitch_angle;
  assign ang.yaw   = in_yaw_angle;

  // front: fold and queue
  e2q_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_ang(ang), .q_valid(qv), .q_take(qt), .q_data(qd)
  );

  // back: CORDIC and products
  e2q_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_take(qt), .q_data(qd),
    .out_empty(out_empty), .out_pop(out_pop), .out_q(q)
  );

  assign out_scalar_part = q.w;
  assign out_i_part      = q.i;
  assign out_j_part      = q.j;
  assign out_k_part      = q.k;

endmodule

// ===== dv/euler_to_quaternion_top_tb.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_top_tb
// Checks the angle-to-quaternion block against its own bit-true predictor
// under several idle/stall mixes, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top_tb import e2q_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] i;
    logic signed [15:0] j;
    logic signed [15:0] k;
  } quat_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [AW-1:0] in_roll_angle = '0;
  logic signed [AW-1:0] in_pitch_angle = '0;
  logic signed [AW-1:0] in_yaw_angle = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [AW-1:0] out_scalar_part, out_i_part, out_j_part, out_k_part;

  // Percent chances of a gap on each side; updated per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int fail_count = 0;
  int sent_count = 0;
  int got_count = 0;
  quat_exp_t quat_queue[$];

  euler_to_quaternion_top u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Arctangent table in Q30, truncated.
  function automatic longint atan_entry(int idx);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tbl[idx];
  endfunction

  // Add half an LSB, then floor (>>> on longint floors).
  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void half_sin_cos(logic signed [15:0] ang, output longint s24,
                                       output longint c24);
    longint z, x, y, nx;
    bit flip;
    int steps;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    // Fold half angles outside +-pi/2 and negate both outputs.
    if (z > 1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int n = 0; n < steps; n++) begin
      if (z >= 0) begin
        nx = x - (y >>> n);
        y = y + (x >>> n);
        z -= atan_entry(n);
      end else begin
        nx = x + (y >>> n);
        y = y - (x >>> n);
        z += atan_entry(n);
      end
      x = nx;
    end
    x = round_sh(x, 6);
    y = round_sh(y, 6);
    if (flip) begin
      x = -x;
      y = -y;
    end
    s24 = y;
    c24 = x;
  endfunction

  function automatic longint trip(longint a, longint b, longint c);
    return round_sh(a * b, 24) * c;
  endfunction

  function automatic logic signed [15:0] clamp_part(longint q48);
    longint v;
    v = round_sh(q48, 34);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic quat_exp_t predict_quat(logic signed [15:0] r, logic signed [15:0] p,
                                             logic signed [15:0] yw);
    longint sr, cr, sp, cp, sy, cy;
    quat_exp_t q;
    half_sin_cos(r, sr, cr);
    half_sin_cos(p, sp, cp);
    half_sin_cos(yw, sy, cy);
    q.w = clamp_part(trip(cr, cp, cy) + trip(sr, sp, sy));
    q.i = clamp_part(trip(sr, cp, cy) - trip(cr, sp, sy));
    q.j = clamp_part(trip(cr, sp, cy) + trip(sr, cp, sy));
    q.k = clamp_part(trip(cr, cp, sy) - trip(sr, sp, cy));
    return q;
  endfunction

  // Offer one triple, honor random idle, hold until the transfer.
  task automatic send_angles(logic signed [15:0] r, logic signed [15:0] p,
                             logic signed [15:0] yw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_roll_angle <= r;
    in_pitch_angle <= p;
    in_yaw_angle <= yw;
    do @(posedge clk); while (in_full);
    quat_queue.push_back(predict_quat(r, p, yw));
    sent_count++;
  endtask

  // Drop push and wait until every expected result has come back.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
  endtask

  // Pop side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each transfer out with the oldest prediction.
  always @(posedge clk) begin
    quat_exp_t e;
    if (rst_n && out_pop && !out_empty) begin
      got_count++;
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected result w=%0d i=%0d j=%0d k=%0d", $realtime,
                 out_scalar_part, out_i_part, out_j_part, out_k_part);
        fail_count++;
      end else begin
        e = quat_queue.pop_front();
        if (e.w !== out_scalar_part || e.i !== out_i_part || e.j !== out_j_part ||
            e.k !== out_k_part) begin
          $display("%0t: expected w=%0d i=%0d j=%0d k=%0d actual w=%0d i=%0d j=%0d k=%0d",
                   $realtime, e.w, e.i, e.j, e.k, out_scalar_part, out_i_part,
                   out_j_part, out_k_part);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'(signed'(32767 - $urandom_range(40)));
      1: return 16'(signed'(-32768 + $urandom_range(40)));
      2: return 16'(signed'(int'($urandom_range(400)) - 200));
      // around +-pi (half angle around +-pi/2): fold boundary
      3: return 16'(signed'((($urandom_range(1) != 0) ? 25736 : -25736) +
                            int'($urandom_range(8)) - 4));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] edge_vals[10] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
      16'sd25736, -16'sd25736, 16'sd25735, 16'sd12868, -16'sd12868};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (edge_vals[n]) send_angles(edge_vals[n], edge_vals[n], edge_vals[n]);
    foreach (edge_vals[n]) send_angles(edge_vals[n], 16'sd0, edge_vals[9 - n]);
    send_angles(16'sd32767, -16'sd32768, 16'sd32767);
    send_angles(-16'sd32768, 16'sd32767, -16'sd32768);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  // Hold the pop side off while the sender keeps offering: fill and stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 200;
    repeat (60) send_angles(rand_angle(), rand_angle(), rand_angle());
    // Pause the sender until everything has come back.
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 74, 0);
    test_random(350, 0, 74);
    test_backpressure();
    test_random(370, 18, 18);
    wait_drained();
    repeat (CORDIC_STEPS + 40) @(posedge clk);
    $display("covered %0d angle triples, %0d quaternions checked, four idle mixes",
             sent_count, got_count);
    if (fail_count == 0 && quat_queue.size() == 0) begin
      $display("euler_to_quaternion_top: match");
    end else begin
      $display("euler_to_quaternion_top: mismatch");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("euler_to_quaternion_top: mismatch");
    $finish;
  end
endmodule
